// ===== rtl/rau_pkg.sv =====
package rau_pkg;

   // Width of the reduced result that must fit (numerator two's complement,
   // denominator positive signed).
   localparam int unsigned WIDTH = 32;
   localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

   localparam int unsigned QDEPTH = 2;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_Q,
      ST_MUL_D,
      ST_COMB,
      ST_TWOS,
      ST_XODD,
      ST_YLOOP,
      ST_DIV,
      ST_CHECK
   } state_type;

   // One queued item, already classified by the front end.
   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
      logic               dbz;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ===== rtl/rau_front.sv =====
module rau_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_a_num,
   input  logic [30:0]        req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic [30:0]        req_b_den,
   output rau_pkg::head_type  head,
   input  logic               pop
);
   import rau_pkg::*;

   item_type mem_ff [QDEPTH];
   logic     wr_ptr_ff, wr_ptr_in;
   logic     rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic     push;
   item_type new_item;

   // Classification: a divide by a zero numerator needs no arithmetic.
   always_comb begin
      new_item.cmd   = cmd_type'(req_cmd);
      new_item.a_num = req_a_num;
      new_item.a_den = req_a_den;
      new_item.b_num = req_b_num;
      new_item.b_den = req_b_den;
      new_item.dbz   = (cmd_type'(req_cmd) == CMD_DIV) && (req_b_num == 32'sd0);
   end

   assign busy = (count_ff == 2'(QDEPTH));
   assign push = start && !busy;

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/rau_back.sv =====
module rau_back (
   input  logic               clock,
   input  logic               reset,
   input  rau_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_div_by_zero,
   output logic               rsp_overflow
);
   import rau_pkg::*;

   state_type state_ff, state_in;
   item_type  item_ff;
   logic signed [63:0] p_ff, q_ff;
   logic [63:0] d_ff;
   logic [63:0] nm_ff, dn_ff, x_ff, y_ff;
   logic [64:0] remn_ff, remd_ff;
   logic [5:0]  k_ff, cnt_ff;
   logic        neg_ff;
   logic        rsp_valid_ff;
   logic signed [31:0] res_num_ff;
   logic [30:0] res_den_ff;
   logic        dbz_ff, ovf_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic signed [32:0] nb_mag;
   logic signed [63:0] n_sum;
   logic [63:0] n_mag;
   logic        n_neg;
   logic [63:0] lo, hi, diff;
   logic [64:0] trial_n, trial_d;
   logic        emit;
   logic        fit_bad;

   // Shared multiplier, one product per cycle, registered before use.
   always_comb begin
      nb_mag = item_ff.b_num[31] ? -33'(item_ff.b_num) : 33'(item_ff.b_num);
      mul_a  = 33'(item_ff.a_num);
      mul_b  = $signed({2'b00, item_ff.b_den});
      unique case (state_ff)
         ST_MUL_P: begin
            mul_a = 33'(item_ff.a_num);
            mul_b = (item_ff.cmd == CMD_MUL) ? 33'(item_ff.b_num)
                                             : $signed({2'b00, item_ff.b_den});
         end
         ST_MUL_Q: begin
            mul_a = 33'(item_ff.b_num);
            mul_b = $signed({2'b00, item_ff.a_den});
         end
         ST_MUL_D: begin
            mul_a = $signed({2'b00, item_ff.a_den});
            mul_b = (item_ff.cmd == CMD_DIV) ? nb_mag : $signed({2'b00, item_ff.b_den});
         end
         default: begin
            mul_a = 33'(item_ff.a_num);
            mul_b = $signed({2'b00, item_ff.b_den});
         end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      case (item_ff.cmd)
         CMD_ADD: n_sum = p_ff + q_ff;
         CMD_SUB: n_sum = p_ff - q_ff;
         default: n_sum = p_ff;
      endcase
      n_mag = n_sum[63] ? -n_sum : n_sum;
      n_neg = n_sum[63] ^ ((item_ff.cmd == CMD_DIV) && item_ff.b_num[31]);
      lo    = (x_ff > y_ff) ? y_ff : x_ff;
      hi    = (x_ff > y_ff) ? x_ff : y_ff;
      diff  = hi - lo;
      trial_n = {remn_ff[63:0], nm_ff[63]};
      trial_d = {remd_ff[63:0], dn_ff[63]};
      fit_bad = (dn_ff > LIM - 64'd1) || (nm_ff > (neg_ff ? LIM : LIM - 64'd1));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (head.valid) state_in = head.item.dbz ? ST_IDLE : ST_MUL_P;
         ST_MUL_P: state_in = ST_MUL_Q;
         ST_MUL_Q: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_COMB;
         ST_COMB:  state_in = (d_ff == 64'd0 || n_mag == 64'd0) ? ST_IDLE : ST_TWOS;
         ST_TWOS:  if (x_ff[0] | y_ff[0]) state_in = ST_XODD;
         ST_XODD:  if (x_ff[0]) state_in = ST_YLOOP;
         ST_YLOOP: if (y_ff[0] && diff == 64'd0) state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 6'd0) state_in = ST_CHECK;
         ST_CHECK: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop  = head.valid;
            emit = head.valid && head.item.dbz;
         end
         ST_COMB:  emit = (d_ff == 64'd0) || (n_mag == 64'd0);
         ST_CHECK: emit = 1'b1;
         default: begin
            pop  = 1'b0;
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               item_ff    <= head.item;
               res_num_ff <= head.item.a_num;
               res_den_ff <= head.item.a_den;
               dbz_ff     <= 1'b1;
               ovf_ff     <= 1'b0;
            end
         end
         ST_MUL_P: p_ff <= prod[63:0];
         ST_MUL_Q: q_ff <= prod[63:0];
         ST_MUL_D: d_ff <= prod[63:0];
         ST_COMB: begin
            x_ff   <= n_mag;
            y_ff   <= d_ff;
            nm_ff  <= n_mag;
            dn_ff  <= d_ff;
            neg_ff <= n_neg;
            k_ff   <= 6'd0;
            res_num_ff <= 32'sd0;
            res_den_ff <= 31'd1;
            dbz_ff     <= 1'b0;
            ovf_ff     <= (d_ff == 64'd0);
         end
         ST_TWOS: begin
            if (!(x_ff[0] | y_ff[0])) begin
               x_ff <= x_ff >> 1;
               y_ff <= y_ff >> 1;
               k_ff <= k_ff + 6'd1;
            end
         end
         ST_XODD: if (!x_ff[0]) x_ff <= x_ff >> 1;
         ST_YLOOP: begin
            if (!y_ff[0]) begin
               y_ff <= y_ff >> 1;
            end else begin
               x_ff <= lo;
               y_ff <= diff;
               if (diff == 64'd0) begin
                  // Strip the common power of two; the odd part divides exactly.
                  nm_ff   <= nm_ff >> k_ff;
                  dn_ff   <= dn_ff >> k_ff;
                  remn_ff <= 65'd0;
                  remd_ff <= 65'd0;
                  cnt_ff  <= 6'd63;
               end
            end
         end
         ST_DIV: begin
            if (trial_n >= {1'b0, x_ff}) begin
               remn_ff <= trial_n - {1'b0, x_ff};
               nm_ff   <= {nm_ff[62:0], 1'b1};
            end else begin
               remn_ff <= trial_n;
               nm_ff   <= {nm_ff[62:0], 1'b0};
            end
            if (trial_d >= {1'b0, x_ff}) begin
               remd_ff <= trial_d - {1'b0, x_ff};
               dn_ff   <= {dn_ff[62:0], 1'b1};
            end else begin
               remd_ff <= trial_d;
               dn_ff   <= {dn_ff[62:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
         end
         ST_CHECK: begin
            dbz_ff <= 1'b0;
            ovf_ff <= fit_bad;
            if (fit_bad) begin
               res_num_ff <= 32'sd0;
               res_den_ff <= 31'd1;
            end else begin
               res_num_ff <= neg_ff ? -$signed(nm_ff[31:0]) : $signed(nm_ff[31:0]);
               res_den_ff <= dn_ff[30:0];
            end
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_num     = res_num_ff;
   assign rsp_res_den     = res_den_ff;
   assign rsp_div_by_zero = dbz_ff;
   assign rsp_overflow    = ovf_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(dbz_ff && ovf_ff))
      else $error("both result flags set");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !dbz_ff) |-> (res_den_ff != 31'd0))
      else $error("computed result has a zero denominator");

   a_odd_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> x_ff[0])
      else $error("divisor is not odd");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE) && head.valid)
      else $error("queue popped while engine busy");

endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit.
// Input channel: an operation on two rationals (req_cmd, req_a_num/req_a_den,
// req_b_num/req_b_den) is taken as one beat at a rising edge where start is
// high and busy is low. Denominators are positive; numerators are signed.
// A two-entry queue sits behind the input, so up to two beats are taken
// while the engine still works; busy rises only when that queue is full.
// Result channel: each beat yields one result beat, shown for exactly one
// cycle with rsp_valid high. The receiver cannot stall the unit, so results
// must be captured in that cycle.
// Order of work: a divide by zero is answered straight from the queue head by
// the idle engine, and a zero denominator or zero numerator at the combine
// step. Other items pass the multiply steps (one shared 33x33 multiplier),
// a binary GCD that steps one shift or subtract per cycle on 64-bit
// products, then shift-subtract division of numerator and denominator in
// parallel, and the fit check. The engine takes the next queued beat in
// the cycle its previous result is shown.
// Reset clears the queue and returns the engine to idle; no result is lost
// or produced by reset other than items in flight being dropped.
module rational_arithmetic_unit_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_a_num,
   input  logic [30:0]        req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic [30:0]        req_b_den,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_div_by_zero,
   output logic               rsp_overflow
);
   import rau_pkg::*;

   head_type head;
   logic     pop;

   // Front end: classifies each beat and holds it until the engine is free.
   rau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_cmd   (req_cmd),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .head      (head),
      .pop       (pop)
   );

   // Back end: cross products, GCD reduction, fit check and result beat.
   rau_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_res_num     (rsp_res_num),
      .rsp_res_den     (rsp_res_den),
      .rsp_div_by_zero (rsp_div_by_zero),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rau_pkg::*;

   // One expected result of the unit.
   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               dbz;
      logic               ovf;
   } ratio_result_type;

   int unsigned mismatch_count = 0;

   // Prints one line per mismatch and keeps the tally for the final verdict.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Computes the reduced rational for one operation.
   function automatic ratio_result_type reduce_ratio(cmd_type op, logic signed [31:0] an,
                                                     logic [30:0] ad, logic signed [31:0] bn,
                                                     logic [30:0] bd);
      ratio_result_type r;
      logic signed [63:0] p, q, n;
      logic [63:0] mag, den, g, x, y, t, lim;
      logic neg;
      int unsigned k;
      r.dbz = 1'b0;
      r.ovf = 1'b0;
      lim = 64'd1 << (WIDTH - 1);
      if (op == CMD_DIV && bn == 0) begin
         r.num = an;
         r.den = ad;
         r.dbz = 1'b1;
         return r;
      end
      if (op == CMD_ADD || op == CMD_SUB) begin
         p = 64'(an) * $signed({33'd0, bd});
         q = 64'(bn) * $signed({33'd0, ad});
         n = (op == CMD_ADD) ? p + q : p - q;
         neg = n < 0;
         mag = neg ? -n : n;
         den = {33'd0, ad} * {33'd0, bd};
      end else begin
         neg = (an < 0) != (bn < 0);
         p = an;
         q = bn;
         x = (p < 0) ? -p : p;
         y = (q < 0) ? -q : q;
         if (op == CMD_MUL) begin
            mag = x * y;
            den = {33'd0, ad} * {33'd0, bd};
         end else begin
            mag = x * {33'd0, bd};
            den = {33'd0, ad} * y;
         end
      end
      r.num = 0;
      r.den = 1;
      if (den == 0) begin
         r.ovf = 1'b1;
         return r;
      end
      // Binary GCD of magnitude and denominator; den is nonzero here.
      if (mag == 0) g = den;
      else begin
         x = mag;
         y = den;
         k = 0;
         while (((x | y) & 1) == 0) begin
            x >>= 1;
            y >>= 1;
            k++;
         end
         while ((x & 1) == 0) x >>= 1;
         do begin
            while ((y & 1) == 0) y >>= 1;
            if (x > y) begin
               t = x;
               x = y;
               y = t;
            end
            y -= x;
         end while (y != 0);
         g = x << k;
      end
      mag /= g;
      den /= g;
      if (mag == 0) neg = 1'b0;
      if (den > lim - 1 || mag > (neg ? lim : lim - 1)) begin
         r.ovf = 1'b1;
         return r;
      end
      r.num = neg ? -mag[31:0] : mag[31:0];
      r.den = den[30:0];
      return r;
   endfunction

   // Holds the results still owed by the unit, oldest first.
   class ratio_scoreboard;
      ratio_result_type pending[$];

      function void note_beat(cmd_type op, logic signed [31:0] an, logic [30:0] ad,
                              logic signed [31:0] bn, logic [30:0] bd);
         pending.push_back(reduce_ratio(op, an, ad, bn, bd));
      endfunction

      task check_beat(logic signed [31:0] num, logic [30:0] den,
                      logic dbz, logic ovf);
         ratio_result_type e;
         if (pending.size() == 0) begin
            report_mismatch("result beat with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (num !== e.num)
            report_mismatch($sformatf("res_num %0d, expected %0d", num, e.num));
         if (den !== e.den)
            report_mismatch($sformatf("res_den %0d, expected %0d", den, e.den));
         if (dbz !== e.dbz)
            report_mismatch($sformatf("div_by_zero %0b, expected %0b", dbz, e.dbz));
         if (ovf !== e.ovf)
            report_mismatch($sformatf("overflow %0b, expected %0b", ovf, e.ovf));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = '0;
   logic signed [31:0] req_a_num = '0;
   logic [30:0]        req_a_den = 31'd1;
   logic signed [31:0] req_b_num = '0;
   logic [30:0]        req_b_den = 31'd1;
   logic               rsp_valid;
   logic signed [31:0] rsp_res_num;
   logic [30:0]        rsp_res_den;
   logic               rsp_div_by_zero;
   logic               rsp_overflow;

   ratio_scoreboard board = new();

   rational_arithmetic_unit_top dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Results cannot be held off, so every strobed cycle is checked at its edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_beat(rsp_res_num, rsp_res_den, rsp_div_by_zero, rsp_overflow);
   end

   // Presents one request beat and holds it until the unit takes it. The
   // expected result is noted at the accepting edge, before any result of
   // the same beat can possibly appear. Start stays high between beats that
   // follow with no gap.
   task automatic send_beat(cmd_type op, logic signed [31:0] an, logic [30:0] ad,
                            logic signed [31:0] bn, logic [30:0] bd);
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do @(posedge clock); while (busy);
      board.note_beat(op, an, ad, bn, bd);
   endtask

   // Numerators favor the edges and small values so that the reduction,
   // overflow and zero cases are hit often.
   function automatic logic signed [31:0] pick_num();
      case ($urandom_range(0, 7))
         0: return 32'(32'sh8000_0000 + $urandom_range(0, 3));
         1: return 32'(32'sh7FFF_FFFF - $urandom_range(0, 3));
         2: return 32'sd0;
         3, 4: return 32'($signed($urandom_range(0, 40)) - 20);
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic logic [30:0] pick_den();
      case ($urandom_range(0, 5))
         0: return 31'(31'h7FFF_FFFF - $urandom_range(0, 3));
         1: return 31'd1;
         2, 3: return 31'($urandom_range(1, 64));
         default: return 31'(($urandom & 32'h7FFF_FFFF) | (32'd1 << $urandom_range(0, 30)));
      endcase
   endfunction

   initial begin
      cmd_type op;
      int unsigned cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: each operation at the extremes, zero results, divide by a
      // zero numerator, and sums that do not fit the width.
      for (int i = 0; i < 4; i++) begin
         op = cmd_type'(i);
         send_beat(op, 32'sh7FFF_FFFF, 31'd1, 32'sh7FFF_FFFF, 31'd1);
         send_beat(op, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 31'd1);
         send_beat(op, 32'sd0, 31'd7, 32'sd3, 31'h7FFF_FFFF);
         send_beat(op, -32'sd1, 31'd2, 32'sd1, 31'd2);
      end
      send_beat(CMD_DIV, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sd0, 31'd5);
      send_beat(CMD_DIV, 32'sd6, 31'd4, 32'sd0, 31'd1);
      send_beat(CMD_MUL, 32'sd6, 31'd4, 32'sd2, 31'd3);
      send_beat(CMD_SUB, 32'sd5, 31'd3, 32'sd5, 31'd3);
      send_beat(CMD_ADD, 32'sh7FFF_FFFF, 31'd1, 32'sd1, 31'd1);

      // Random part.
      for (int i = 0; i < 1650; i++) begin
         op = cmd_type'($urandom_range(0, 3));
         send_beat(op, pick_num(), pick_den(), pick_num(), pick_den());
      end
      start <= 1'b0;

      cycles = 0;
      while (board.pending.size() != 0 && cycles < 20000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && board.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Slowest correct run: about 1700 beats, each at its longest, plus gaps.
   initial begin
      #(12ns * 1700 * 350 * 3);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
